// ----- rtl/sled_pkg.sv -----
// Package for the string literal escape decoder: types, codes and the
// UTF-8 prefix tree lookup. No dependencies.
`default_nettype none
package sled_pkg;

    localparam logic [2:0] E_OK         = 3'd0;
    localparam logic [2:0] E_UNFINISHED = 3'd1;
    localparam logic [2:0] E_NEWLINE    = 3'd2;
    localparam logic [2:0] E_BADESC     = 3'd3;
    localparam logic [2:0] E_HEX        = 3'd4;
    localparam logic [2:0] E_DECBIG     = 3'd5;
    localparam logic [2:0] E_UTF8       = 3'd6;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_NORMAL  = 8'b0000_0010,
        M_ESC     = 8'b0000_0100,
        M_HEX     = 8'b0000_1000,
        M_DEC     = 8'b0001_0000,
        M_ZAP     = 8'b0010_0000,
        M_PARTNER = 8'b0100_0000,
        M_TREE    = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       at_end;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    // Classified work for the back end: up to two results per input.
    typedef struct packed {
        logic      two;
        out_item_t r0;
        out_item_t r1;
    } work_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic       hit;
        logic       leaf;
        logic [7:0] target;
    } edge_hit_t;

    function automatic edge_hit_t tree_lookup(input logic [5:0] node, input logic [7:0] b);
        edge_hit_t r;
        logic [13:0] k;
        r = '0;
        k = {node, b};
        r.hit = 1'b1;
        case (k)
            {6'd0,8'he2}: begin r.leaf=0; r.target=8'd1; end
            {6'd0,8'he3}: begin r.leaf=0; r.target=8'd27; end
            {6'd0,8'hc2}: begin r.leaf=0; r.target=8'd32; end
            {6'd0,8'hf0}: begin r.leaf=0; r.target=8'd33; end
            {6'd0,8'hec}: begin r.leaf=0; r.target=8'd41; end
            {6'd0,8'hcb}: begin r.leaf=0; r.target=8'd43; end
            {6'd0,8'he1}: begin r.leaf=0; r.target=8'd44; end
            {6'd1,8'h96}: begin r.leaf=0; r.target=8'd2; end
            {6'd1,8'h81}: begin r.leaf=0; r.target=8'd3; end
            {6'd1,8'h80}: begin r.leaf=0; r.target=8'd4; end
            {6'd1,8'h97}: begin r.leaf=0; r.target=8'd5; end
            {6'd1,8'hac}: begin r.leaf=0; r.target=8'd6; end
            {6'd1,8'h9c}: begin r.leaf=0; r.target=8'd16; end
            {6'd1,8'h99}: begin r.leaf=0; r.target=8'd17; end
            {6'd1,8'h98}: begin r.leaf=0; r.target=8'd18; end
            {6'd1,8'h8c}: begin r.leaf=0; r.target=8'd19; end
            {6'd1,8'h9e}: begin r.leaf=0; r.target=8'd20; end
            {6'd1,8'ha7}: begin r.leaf=0; r.target=8'd24; end
            {6'd1,8'h88}: begin r.leaf=0; r.target=8'd25; end
            {6'd1,8'h9d}: begin r.leaf=0; r.target=8'd26; end
            {6'd2,8'hae}: begin r.leaf=1; r.target=8'd16; end
            {6'd2,8'ha0}: begin r.leaf=1; r.target=8'd17; end
            {6'd2,8'ha1}: begin r.leaf=1; r.target=8'd18; end
            {6'd2,8'hb6}: begin r.leaf=1; r.target=8'd23; end
            {6'd2,8'h88}: begin r.leaf=1; r.target=8'd128; end
            {6'd2,8'h92}: begin r.leaf=1; r.target=8'd129; end
            {6'd2,8'h91}: begin r.leaf=1; r.target=8'd132; end
            {6'd2,8'ha4}: begin r.leaf=1; r.target=8'd152; end
            {6'd2,8'ha5}: begin r.leaf=1; r.target=8'd153; end
            {6'd3,8'h99}: begin r.leaf=1; r.target=8'd19; end
            {6'd3,8'h98}: begin r.leaf=1; r.target=8'd20; end
            {6'd3,8'hb4}: begin r.leaf=1; r.target=8'd4; end
            {6'd3,8'hb5}: begin r.leaf=1; r.target=8'd5; end
            {6'd3,8'hb6}: begin r.leaf=1; r.target=8'd6; end
            {6'd3,8'hb7}: begin r.leaf=1; r.target=8'd7; end
            {6'd3,8'hb8}: begin r.leaf=1; r.target=8'd8; end
            {6'd4,8'h96}: begin r.leaf=1; r.target=8'd21; end
            {6'd4,8'ha2}: begin r.leaf=1; r.target=8'd27; end
            {6'd4,8'ha6}: begin r.leaf=1; r.target=8'd144; end
            {6'd5,8'h80}: begin r.leaf=1; r.target=8'd22; end
            {6'd5,8'h8b}: begin r.leaf=1; r.target=8'd127; end
            {6'd5,8'h8f}: begin r.leaf=1; r.target=8'd134; end
            {6'd5,8'h86}: begin r.leaf=1; r.target=8'd143; end
            {6'd5,8'h9c}: begin r.leaf=1; r.target=8'd254; end
            {6'd5,8'h9d}: begin r.leaf=1; r.target=8'd255; end
            {6'd6,8'h87}: begin r.leaf=0; r.target=8'd7; end
            {6'd6,8'h85}: begin r.leaf=0; r.target=8'd10; end
            {6'd6,8'h86}: begin r.leaf=0; r.target=8'd13; end
            {6'd7,8'hef}: begin r.leaf=0; r.target=8'd8; end
            {6'd8,8'hb8}: begin r.leaf=0; r.target=8'd9; end
            {6'd9,8'h8f}: begin r.leaf=1; r.target=8'd131; end
            {6'd10,8'hef}: begin r.leaf=0; r.target=8'd11; end
            {6'd11,8'hb8}: begin r.leaf=0; r.target=8'd12; end
            {6'd12,8'h8f}: begin r.leaf=1; r.target=8'd139; end
            {6'd13,8'hef}: begin r.leaf=0; r.target=8'd14; end
            {6'd14,8'hb8}: begin r.leaf=0; r.target=8'd15; end
            {6'd15,8'h8f}: begin r.leaf=1; r.target=8'd148; end
            {6'd16,8'hbd}: begin r.leaf=1; r.target=8'd133; end
            {6'd17,8'ha5}: begin r.leaf=1; r.target=8'd135; end
            {6'd17,8'haa}: begin r.leaf=1; r.target=8'd141; end
            {6'd18,8'h89}: begin r.leaf=1; r.target=8'd136; end
            {6'd18,8'h85}: begin r.leaf=1; r.target=8'd146; end
            {6'd19,8'h82}: begin r.leaf=1; r.target=8'd138; end
            {6'd20,8'ha1}: begin r.leaf=0; r.target=8'd21; end
            {6'd21,8'hef}: begin r.leaf=0; r.target=8'd22; end
            {6'd22,8'hb8}: begin r.leaf=0; r.target=8'd23; end
            {6'd23,8'h8f}: begin r.leaf=1; r.target=8'd145; end
            {6'd24,8'h97}: begin r.leaf=1; r.target=8'd147; end
            {6'd25,8'ha7}: begin r.leaf=1; r.target=8'd150; end
            {6'd26,8'h8e}: begin r.leaf=1; r.target=8'd151; end
            {6'd27,8'h80}: begin r.leaf=0; r.target=8'd28; end
            {6'd27,8'h82}: begin r.leaf=0; r.target=8'd29; end
            {6'd27,8'h81}: begin r.leaf=0; r.target=8'd30; end
            {6'd27,8'h83}: begin r.leaf=0; r.target=8'd31; end
            {6'd28,8'h8c}: begin r.leaf=1; r.target=8'd24; end
            {6'd28,8'h8d}: begin r.leaf=1; r.target=8'd25; end
            {6'd28,8'h81}: begin r.leaf=1; r.target=8'd28; end
            {6'd28,8'h82}: begin r.leaf=1; r.target=8'd29; end
            {6'd29,8'h9b}: begin r.leaf=1; r.target=8'd30; end
            {6'd29,8'h9c}: begin r.leaf=1; r.target=8'd31; end
            {6'd29,8'h80}: begin r.leaf=1; r.target=8'd186; end
            {6'd29,8'h81}: begin r.leaf=1; r.target=8'd187; end
            {6'd29,8'h82}: begin r.leaf=1; r.target=8'd188; end
            {6'd29,8'h84}: begin r.leaf=1; r.target=8'd189; end
            {6'd29,8'h86}: begin r.leaf=1; r.target=8'd190; end
            {6'd29,8'h88}: begin r.leaf=1; r.target=8'd191; end
            {6'd29,8'h89}: begin r.leaf=1; r.target=8'd192; end
            {6'd29,8'h8a}: begin r.leaf=1; r.target=8'd193; end
            {6'd29,8'h8b}: begin r.leaf=1; r.target=8'd194; end
            {6'd29,8'h8c}: begin r.leaf=1; r.target=8'd195; end
            {6'd29,8'h8d}: begin r.leaf=1; r.target=8'd196; end
            {6'd29,8'h8f}: begin r.leaf=1; r.target=8'd197; end
            {6'd29,8'h92}: begin r.leaf=1; r.target=8'd198; end
            {6'd29,8'h93}: begin r.leaf=1; r.target=8'd199; end
            {6'd29,8'h83}: begin r.leaf=1; r.target=8'd201; end
            {6'd29,8'h85}: begin r.leaf=1; r.target=8'd202; end
            {6'd29,8'h87}: begin r.leaf=1; r.target=8'd203; end
            {6'd29,8'ha2}: begin r.leaf=1; r.target=8'd204; end
            {6'd29,8'ha4}: begin r.leaf=1; r.target=8'd205; end
            {6'd29,8'ha6}: begin r.leaf=1; r.target=8'd206; end
            {6'd29,8'ha8}: begin r.leaf=1; r.target=8'd207; end
            {6'd29,8'haa}: begin r.leaf=1; r.target=8'd208; end
            {6'd29,8'hab}: begin r.leaf=1; r.target=8'd209; end
            {6'd29,8'had}: begin r.leaf=1; r.target=8'd210; end
            {6'd29,8'haf}: begin r.leaf=1; r.target=8'd211; end
            {6'd29,8'hb1}: begin r.leaf=1; r.target=8'd212; end
            {6'd29,8'hb3}: begin r.leaf=1; r.target=8'd213; end
            {6'd29,8'hb5}: begin r.leaf=1; r.target=8'd214; end
            {6'd29,8'hb7}: begin r.leaf=1; r.target=8'd215; end
            {6'd29,8'hb9}: begin r.leaf=1; r.target=8'd216; end
            {6'd29,8'hbb}: begin r.leaf=1; r.target=8'd217; end
            {6'd29,8'hbd}: begin r.leaf=1; r.target=8'd218; end
            {6'd29,8'hbf}: begin r.leaf=1; r.target=8'd219; end
            {6'd30,8'h82}: begin r.leaf=1; r.target=8'd154; end
            {6'd30,8'h84}: begin r.leaf=1; r.target=8'd155; end
            {6'd30,8'h86}: begin r.leaf=1; r.target=8'd156; end
            {6'd30,8'h88}: begin r.leaf=1; r.target=8'd157; end
            {6'd30,8'h8a}: begin r.leaf=1; r.target=8'd158; end
            {6'd30,8'h8b}: begin r.leaf=1; r.target=8'd159; end
            {6'd30,8'h8d}: begin r.leaf=1; r.target=8'd160; end
            {6'd30,8'h8f}: begin r.leaf=1; r.target=8'd161; end
            {6'd30,8'h91}: begin r.leaf=1; r.target=8'd162; end
            {6'd30,8'h93}: begin r.leaf=1; r.target=8'd163; end
            {6'd30,8'h95}: begin r.leaf=1; r.target=8'd164; end
            {6'd30,8'h97}: begin r.leaf=1; r.target=8'd165; end
            {6'd30,8'h99}: begin r.leaf=1; r.target=8'd166; end
            {6'd30,8'h9b}: begin r.leaf=1; r.target=8'd167; end
            {6'd30,8'h9d}: begin r.leaf=1; r.target=8'd168; end
            {6'd30,8'h9f}: begin r.leaf=1; r.target=8'd169; end
            {6'd30,8'ha1}: begin r.leaf=1; r.target=8'd170; end
            {6'd30,8'ha4}: begin r.leaf=1; r.target=8'd171; end
            {6'd30,8'ha6}: begin r.leaf=1; r.target=8'd172; end
            {6'd30,8'ha8}: begin r.leaf=1; r.target=8'd173; end
            {6'd30,8'haa}: begin r.leaf=1; r.target=8'd174; end
            {6'd30,8'hab}: begin r.leaf=1; r.target=8'd175; end
            {6'd30,8'hac}: begin r.leaf=1; r.target=8'd176; end
            {6'd30,8'had}: begin r.leaf=1; r.target=8'd177; end
            {6'd30,8'hae}: begin r.leaf=1; r.target=8'd178; end
            {6'd30,8'haf}: begin r.leaf=1; r.target=8'd179; end
            {6'd30,8'hb2}: begin r.leaf=1; r.target=8'd180; end
            {6'd30,8'hb5}: begin r.leaf=1; r.target=8'd181; end
            {6'd30,8'hb8}: begin r.leaf=1; r.target=8'd182; end
            {6'd30,8'hbb}: begin r.leaf=1; r.target=8'd183; end
            {6'd30,8'hbe}: begin r.leaf=1; r.target=8'd184; end
            {6'd30,8'hbf}: begin r.leaf=1; r.target=8'd185; end
            {6'd30,8'ha3}: begin r.leaf=1; r.target=8'd200; end
            {6'd31,8'h81}: begin r.leaf=1; r.target=8'd220; end
            {6'd31,8'h84}: begin r.leaf=1; r.target=8'd221; end
            {6'd31,8'h86}: begin r.leaf=1; r.target=8'd222; end
            {6'd31,8'h88}: begin r.leaf=1; r.target=8'd223; end
            {6'd31,8'h8a}: begin r.leaf=1; r.target=8'd224; end
            {6'd31,8'h8b}: begin r.leaf=1; r.target=8'd225; end
            {6'd31,8'h8c}: begin r.leaf=1; r.target=8'd226; end
            {6'd31,8'h8d}: begin r.leaf=1; r.target=8'd227; end
            {6'd31,8'h8e}: begin r.leaf=1; r.target=8'd228; end
            {6'd31,8'h8f}: begin r.leaf=1; r.target=8'd229; end
            {6'd31,8'h92}: begin r.leaf=1; r.target=8'd230; end
            {6'd31,8'h95}: begin r.leaf=1; r.target=8'd231; end
            {6'd31,8'h98}: begin r.leaf=1; r.target=8'd232; end
            {6'd31,8'h9b}: begin r.leaf=1; r.target=8'd233; end
            {6'd31,8'h9e}: begin r.leaf=1; r.target=8'd234; end
            {6'd31,8'h9f}: begin r.leaf=1; r.target=8'd235; end
            {6'd31,8'ha0}: begin r.leaf=1; r.target=8'd236; end
            {6'd31,8'ha1}: begin r.leaf=1; r.target=8'd237; end
            {6'd31,8'ha2}: begin r.leaf=1; r.target=8'd238; end
            {6'd31,8'ha4}: begin r.leaf=1; r.target=8'd239; end
            {6'd31,8'ha6}: begin r.leaf=1; r.target=8'd240; end
            {6'd31,8'ha8}: begin r.leaf=1; r.target=8'd241; end
            {6'd31,8'ha9}: begin r.leaf=1; r.target=8'd242; end
            {6'd31,8'haa}: begin r.leaf=1; r.target=8'd243; end
            {6'd31,8'hab}: begin r.leaf=1; r.target=8'd244; end
            {6'd31,8'hac}: begin r.leaf=1; r.target=8'd245; end
            {6'd31,8'had}: begin r.leaf=1; r.target=8'd246; end
            {6'd31,8'haf}: begin r.leaf=1; r.target=8'd247; end
            {6'd31,8'hb2}: begin r.leaf=1; r.target=8'd248; end
            {6'd31,8'hb3}: begin r.leaf=1; r.target=8'd249; end
            {6'd31,8'h83}: begin r.leaf=1; r.target=8'd250; end
            {6'd31,8'ha3}: begin r.leaf=1; r.target=8'd251; end
            {6'd31,8'ha5}: begin r.leaf=1; r.target=8'd252; end
            {6'd31,8'ha7}: begin r.leaf=1; r.target=8'd253; end
            {6'd32,8'ha5}: begin r.leaf=1; r.target=8'd26; end
            {6'd32,8'hb9}: begin r.leaf=1; r.target=8'd1; end
            {6'd32,8'hb2}: begin r.leaf=1; r.target=8'd2; end
            {6'd32,8'hb3}: begin r.leaf=1; r.target=8'd3; end
            {6'd33,8'h9f}: begin r.leaf=0; r.target=8'd34; end
            {6'd34,8'h90}: begin r.leaf=0; r.target=8'd35; end
            {6'd34,8'h98}: begin r.leaf=0; r.target=8'd36; end
            {6'd34,8'h85}: begin r.leaf=0; r.target=8'd37; end
            {6'd35,8'hb1}: begin r.leaf=1; r.target=8'd130; end
            {6'd36,8'h90}: begin r.leaf=1; r.target=8'd140; end
            {6'd37,8'hbe}: begin r.leaf=0; r.target=8'd38; end
            {6'd38,8'hef}: begin r.leaf=0; r.target=8'd39; end
            {6'd39,8'hb8}: begin r.leaf=0; r.target=8'd40; end
            {6'd40,8'h8f}: begin r.leaf=1; r.target=8'd142; end
            {6'd41,8'h9b}: begin r.leaf=0; r.target=8'd42; end
            {6'd42,8'h83}: begin r.leaf=1; r.target=8'd137; end
            {6'd43,8'h87}: begin r.leaf=1; r.target=8'd149; end
            {6'd44,8'hb5}: begin r.leaf=0; r.target=8'd45; end
            {6'd44,8'hb6}: begin r.leaf=0; r.target=8'd46; end
            {6'd45,8'h87}: begin r.leaf=1; r.target=8'd11; end
            {6'd45,8'h89}: begin r.leaf=1; r.target=8'd14; end
            {6'd46,8'h9c}: begin r.leaf=1; r.target=8'd12; end
            {6'd46,8'ha0}: begin r.leaf=1; r.target=8'd15; end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sled_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct.
// Depends on sled_pkg.
`default_nettype none
interface sled_in_if;
    import sled_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sled_out_if;
    import sled_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/sled_front.sv -----
// Front end: decoder state machine, classifies each byte into up to two results.
// Depends on sled_pkg.
`default_nettype none
module sled_front
    import sled_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          wr_en,
    output work_t         wr_work,
    input  wire logic     q_full
);
    mode_t       mode_reg, mode_next;
    logic [7:0]  delim_reg, delim_next;
    logic [9:0]  val_reg, val_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [5:0]  node_reg, node_next;
    logic        cr_reg, cr_next;

    logic [7:0]  b;
    logic        fin;
    logic        take;
    logic [3:0]  hexd;
    logic        is_hex, is_dig, is_ws, is_nl;
    logic [9:0]  hex_acc;
    logic [13:0] dec_acc;
    edge_hit_t   root_hit, walk_hit;
    out_item_t   res [2];
    logic [1:0]  nres;

    assign in_ready = !q_full;
    assign take = in_valid && in_ready;
    assign b = in_item.data_byte;
    assign fin = in_item.at_end;

    always_comb
    begin
        is_dig = (b >= 8'h30) && (b <= 8'h39);
        is_hex = is_dig || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
        if (is_dig)
            hexd = b[3:0];
        else
            hexd = b[3:0] + 4'd9;
        is_ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
        is_nl = (b == 8'h0a) || (b == 8'h0d);
        hex_acc = {val_reg[5:0], hexd};
        dec_acc = {val_reg, 3'b0} + {3'b0, val_reg, 1'b0} + {10'b0, b[3:0]};
    end

    assign root_hit = tree_lookup(6'd0, b);
    assign walk_hit = tree_lookup(node_reg, b);

    always_comb
    begin
        logic nb;
        logic [7:0] ec;
        mode_next  = mode_reg;
        delim_next = delim_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        node_next  = node_reg;
        cr_next    = cr_reg;
        res[0] = '0;
        res[1] = '0;
        nres = 2'd0;
        nb = 1'b0;
        ec = 8'd0;

        if (in_item.first && !fin)
        begin
            mode_next = M_NORMAL;
            delim_next = b;
            val_next = '0;
            cnt_next = '0;
            node_next = '0;
            cr_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                M_IDLE: ;
                M_NORMAL: nb = 1'b1;
                M_ESC:
                begin
                    mode_next = M_NORMAL;
                    if (fin)
                    begin
                        res[0].error_code = E_UNFINISHED;
                        nres = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        case (b)
                            8'h2a: ec = 8'd1;
                            8'h23: ec = 8'd2;
                            8'h2d: ec = 8'd3;
                            8'h7c: ec = 8'd4;
                            8'h2b: ec = 8'd5;
                            8'h5e: ec = 8'd6;
                            8'h61: ec = 8'd7;
                            8'h62: ec = 8'd8;
                            8'h66: ec = 8'd12;
                            8'h6e: ec = 8'd10;
                            8'h72: ec = 8'd13;
                            8'h74: ec = 8'd9;
                            8'h76: ec = 8'd11;
                            8'h5c, 8'h22, 8'h27: ec = b;
                            8'h0a, 8'h0d: ec = 8'd10;
                            default: ec = 8'd0;
                        endcase
                        if (b == 8'h78)
                        begin
                            val_next = '0;
                            cnt_next = '0;
                            mode_next = M_HEX;
                        end
                        else if (b == 8'h7a)
                            mode_next = M_ZAP;
                        else if (is_dig)
                        begin
                            val_next = {6'd0, b[3:0]};
                            cnt_next = 2'd1;
                            mode_next = M_DEC;
                        end
                        else if (ec == 8'd0)
                        begin
                            res[0].error_code = E_BADESC;
                            nres = 2'd1;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            res[0].out_byte = ec;
                            res[0].byte_valid = 1'b1;
                            nres = 2'd1;
                            if (is_nl)
                            begin
                                cr_next = (b == 8'h0d);
                                mode_next = M_PARTNER;
                            end
                        end
                    end
                end
                M_HEX:
                begin
                    if (fin || !is_hex)
                    begin
                        res[0].error_code = E_HEX;
                        nres = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        val_next = hex_acc;
                        cnt_next = cnt_reg + 2'd1;
                        if (cnt_reg == 2'd1)
                        begin
                            res[0].out_byte = hex_acc[7:0];
                            res[0].byte_valid = 1'b1;
                            nres = 2'd1;
                            mode_next = M_NORMAL;
                        end
                    end
                end
                M_DEC:
                begin
                    if (!fin && is_dig)
                    begin
                        val_next = dec_acc[9:0];
                        cnt_next = cnt_reg + 2'd1;
                        if (cnt_reg == 2'd2)
                        begin
                            nres = 2'd1;
                            if (dec_acc > 14'd255)
                            begin
                                res[0].error_code = E_DECBIG;
                                mode_next = M_IDLE;
                            end
                            else
                            begin
                                res[0].out_byte = dec_acc[7:0];
                                res[0].byte_valid = 1'b1;
                                mode_next = M_NORMAL;
                            end
                        end
                    end
                    else
                    begin
                        res[0].out_byte = val_reg[7:0];
                        res[0].byte_valid = 1'b1;
                        nres = 2'd1;
                        nb = 1'b1;
                    end
                end
                M_ZAP: nb = fin || !is_ws;
                M_PARTNER:
                begin
                    if (!fin && is_nl && ((b == 8'h0d) != cr_reg))
                        mode_next = M_NORMAL;
                    else
                        nb = 1'b1;
                end
                M_TREE:
                begin
                    nres = 2'd1;
                    if (fin)
                    begin
                        res[0].error_code = E_UTF8;
                        mode_next = M_IDLE;
                    end
                    else if (!walk_hit.hit)
                    begin
                        node_next = '0;
                        res[0].error_code = E_UTF8;
                        mode_next = M_IDLE;
                    end
                    else if (walk_hit.leaf)
                    begin
                        node_next = '0;
                        res[0].out_byte = walk_hit.target;
                        res[0].byte_valid = 1'b1;
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        nres = 2'd0;
                        node_next = walk_hit.target[5:0];
                    end
                end
                default: ;
            endcase

            if (nb)
            begin
                out_item_t r;
                r = '0;
                mode_next = M_NORMAL;
                if (fin)
                begin
                    r.error_code = E_UNFINISHED;
                    mode_next = M_IDLE;
                end
                else if (b == delim_reg)
                begin
                    r.done_res = 1'b1;
                    mode_next = M_IDLE;
                end
                else if (is_nl)
                begin
                    r.error_code = E_NEWLINE;
                    mode_next = M_IDLE;
                end
                else if (b == 8'h5c)
                    mode_next = M_ESC;
                else if (root_hit.hit && !root_hit.leaf)
                begin
                    node_next = root_hit.target[5:0];
                    mode_next = M_TREE;
                end
                else
                begin
                    r.out_byte = b;
                    r.byte_valid = 1'b1;
                end
                if (r.byte_valid || r.done_res || r.error_code != E_OK)
                begin
                    if (nres == 2'd0)
                        res[0] = r;
                    else
                        res[1] = r;
                    nres = nres + 2'd1;
                end
            end
        end
        if (nres == 2'd1)
            res[0].last = 1'b1;
        if (nres == 2'd2)
            res[1].last = 1'b1;
    end

    assign wr_en = take && (nres != 2'd0);
    assign wr_work = '{two: nres[1], r0: res[0], r1: res[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            delim_reg <= '0;
            val_reg   <= '0;
            cnt_reg   <= '0;
            node_reg  <= '0;
            cr_reg    <= 1'b0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            delim_reg <= delim_next;
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            node_reg  <= node_next;
            cr_reg    <= cr_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sled_queue.sv -----
// Short FIFO of classified work between front and back ends.
// Depends on sled_pkg.
`default_nettype none
module sled_queue
    import sled_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire work_t wr_work,
    output logic       full,
    output logic       rd_valid,
    output work_t      rd_work,
    input  wire logic  rd_en
);
    work_t          slot_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;

    assign full = (cnt_reg == (QAW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_work = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sled_back.sv -----
// Back end: pops work entries and sends their one or two results out.
// Depends on sled_pkg.
`default_nettype none
module sled_back
    import sled_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  rd_valid,
    input  wire work_t rd_work,
    output logic       rd_en,
    output logic       out_valid,
    output out_item_t  out_item,
    input  wire logic  out_ready
);
    logic sec_reg;
    logic fire;

    assign out_valid = rd_valid;
    assign out_item = sec_reg ? rd_work.r1 : rd_work.r0;
    assign fire = out_valid && out_ready;
    assign rd_en = fire && (sec_reg || !rd_work.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sec_reg <= 1'b0;
        else if (fire)
            sec_reg <= !sec_reg && rd_work.two;
    end
endmodule
`default_nettype wire

// ----- rtl/string_literal_escape_decoder.sv -----
// String literal escape decoder, top level: front end, work queue, back end.
// Each result is written into the work queue when its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; a byte giving
// two results holds the output for both, and the four-entry queue absorbs it.
// Reset: asynchronous, active low; idle, no literal open, queue empty.
`default_nettype none
module string_literal_escape_decoder
    import sled_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sled_in_if.sink  in_ch,
    sled_out_if.source out_ch
);
    logic  wr_en, q_full, rd_valid, rd_en;
    work_t wr_work, rd_work;

    sled_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
        .wr_en(wr_en), .wr_work(wr_work), .q_full(q_full)
    );

    sled_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_work(wr_work), .full(q_full),
        .rd_valid(rd_valid), .rd_work(rd_work), .rd_en(rd_en)
    );

    sled_back u_back (
        .clk(clk), .rst_n(rst_n),
        .rd_valid(rd_valid), .rd_work(rd_work), .rd_en(rd_en),
        .out_valid(out_ch.valid), .out_item(out_ch.payload), .out_ready(out_ch.ready)
    );

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> $countones({out_ch.payload.byte_valid, out_ch.payload.done_res,
                                     out_ch.payload.error_code != E_OK}) == 1)
        else $error("result is not exactly one kind");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.payload.done_res || out_ch.payload.error_code != E_OK))
        |-> out_ch.payload.last)
        else $error("done or error result not last");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr_en)
        else $error("queue written while full");
endmodule
`default_nettype wire
